// File: rtl/fls_pkg.sv
package fls_pkg;

  localparam int unsigned AngleW  = 32;
  localparam int unsigned ResW    = 32;
  localparam int unsigned DefLanes = 4;
  localparam int unsigned PipeDepth = 10;

  localparam logic signed [56:0] PiQ52     = 57'sh3243F6A8885A31;
  localparam logic signed [56:0] HalfPiQ52 = 57'sh1921FB54442D18;
  localparam logic signed [57:0] TwoPiQ52  = 58'sh6487ED5110B462;
  localparam logic signed [31:0] Inv2PiQ32 = 32'sh28BE60DC;

  typedef logic signed [31:0] coef_t;

  localparam coef_t SinCoef [6] = '{
    -32'sd26, 32'sd2956, -32'sd213040, 32'sd8947846, -32'sd178956974, 32'sd1073741824
  };
  localparam coef_t CosCoef [6] = '{
    -32'sd280, 32'sd26586, -32'sd1491253, 32'sd44739212, -32'sd536870912, 32'sd1073741824
  };

endpackage

// File: rtl/fls_lane.sv
module fls_lane (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [31:0]  angle_i,
  output logic signed [31:0]  sin_o,
  output logic signed [31:0]  cos_o
);

  // range reduction
  logic signed [31:0] x_q;
  logic signed [62:0] p_q;
  logic signed [7:0]  n;
  logic signed [63:0] r_full;
  logic signed [56:0] r_q;
  logic signed [62:0] p_rnd;

  assign p_rnd  = p_q + (63'sd1 <<< 54);
  assign n      = 8'(p_rnd >>> 55);
  assign r_full = ({{32{x_q[31]}}, x_q} <<< 29) - (64'(n) * 64'(fls_pkg::TwoPiQ52));

  // fold
  logic signed [56:0] mag, r_fold, r_half;
  logic               fold;
  logic signed [31:0] a_q;
  logic               neg_q;

  assign mag    = r_q[56] ? -r_q : r_q;
  assign fold   = mag > fls_pkg::HalfPiQ52;
  assign r_fold = fold ? ((r_q[56] ? -fls_pkg::PiQ52 : fls_pkg::PiQ52) - r_q) : r_q;
  assign r_half = r_fold + (57'sd1 <<< 21);

  // square
  logic signed [63:0] aa;
  logic signed [33:0] z_p [5];
  logic signed [31:0] a_p [6];
  logic               neg_p [6];
  logic signed [33:0] ts_p [6];
  logic signed [33:0] tc_p [6];

  assign aa = a_q * a_q + (64'sd1 <<< 29);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q      <= angle_i;
      p_q      <= angle_i * fls_pkg::Inv2PiQ32;
      r_q      <= r_full[56:0];
      a_q      <= 32'(r_half >>> 22);
      neg_q    <= fold;
      z_p[0]   <= 34'(aa >>> 30);
      a_p[0]   <= a_q;
      neg_p[0] <= neg_q;
    end
  end

  assign ts_p[0] = 34'(fls_pkg::SinCoef[0]);
  assign tc_p[0] = 34'(fls_pkg::CosCoef[0]);

  // one Horner step per stage, both polynomials side by side
  for (genvar k = 1; k < 6; k++) begin : g_horner
    logic signed [67:0] ps, pc;
    logic signed [33:0] ts_q, tc_q;
    assign ps = ts_p[k-1] * z_p[k-1] + (68'sd1 <<< 29);
    assign pc = tc_p[k-1] * z_p[k-1] + (68'sd1 <<< 29);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ts_q     <= 34'(ps >>> 30) + 34'(fls_pkg::SinCoef[k]);
        tc_q     <= 34'(pc >>> 30) + 34'(fls_pkg::CosCoef[k]);
        a_p[k]   <= a_p[k-1];
        neg_p[k] <= neg_p[k-1];
      end
    end
    // the last step has no later consumer of z
    if (k < 5) begin : g_z
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_p[k] <= z_p[k-1];
        end
      end
    end
    assign ts_p[k] = ts_q;
    assign tc_p[k] = tc_q;
  end

  logic signed [65:0] sp;
  logic signed [31:0] sin_q, cos_q;
  assign sp = ts_p[5] * a_p[5] + (66'sd1 <<< 29);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= 32'(sp >>> 30);
      cos_q <= neg_p[5] ? -tc_p[5][31:0] : tc_p[5][31:0];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// File: rtl/four_lane_sine_cosine.sv
// four_lane_sine_cosine: sine and cosine of LANES angles per item.
// Slave channel s_axis_*: one item carries LANES angles, signed Q8.23 radians.
// Master channel m_axis_*: one item carries LANES sines then LANES cosines,
// each signed Q1.30.
// Each lane is a ten-stage pipeline: turn estimate multiply, remainder,
// fold and round, square, five Horner steps (sine and cosine in parallel),
// final sine multiply and cosine sign. Valid bits travel with the items, one
// per stage, and the last of them is tvalid; throughput is one item per
// cycle while the receiver does not stall, set by the single pipeline
// advance enable shared by all lanes.
// The last stage is the output register. When the receiver stalls with a
// result waiting, hold the whole pipeline and drop tready; otherwise advance
// every cycle, bubbles included.
// Reset clears the valid bits only; no item is in flight afterwards and the
// data registers hold whatever they had.
module four_lane_sine_cosine #(
  parameter int unsigned LANES = fls_pkg::DefLanes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // angle_0 .. angle_{LANES-1}, 32 bits each, lowest first
  input  logic [LANES*fls_pkg::AngleW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // sin_0 .. sin_{LANES-1}, then cos_0 .. cos_{LANES-1}, 32 bits each
  output logic [2*LANES*fls_pkg::ResW-1:0]  m_axis_tdata
);

  localparam int unsigned Depth = fls_pkg::PipeDepth;

  logic             en;
  logic [Depth-1:0] vld_q, vld_d;

  // advance unless a finished item is held by the receiver
  assign en = !vld_q[Depth-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign vld_d = {vld_q[Depth-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  assign m_axis_tvalid = vld_q[Depth-1];

  // lanes, merged into one result word
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [31:0] s, c;
    fls_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .angle_i (s_axis_tdata[i*fls_pkg::AngleW +: fls_pkg::AngleW]),
      .sin_o   (s),
      .cos_o   (c)
    );
    assign m_axis_tdata[i*fls_pkg::ResW +: fls_pkg::ResW]         = s;
    assign m_axis_tdata[(LANES+i)*fls_pkg::ResW +: fls_pkg::ResW] = c;
  end

`ifndef SYNTHESIS
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("tready does not follow output stall");
  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(vld_q)))
    else $error("pipeline moved while stalled");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted item lost at entry");
`endif

endmodule

// File: tb/tb_four_lane_sine_cosine.sv
module tb_four_lane_sine_cosine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumLanes = 4;
  localparam int unsigned InW  = NumLanes * fls_pkg::AngleW;
  localparam int unsigned OutW = 2 * NumLanes * fls_pkg::ResW;
  localparam int unsigned AngW = fls_pkg::AngleW;
  localparam int unsigned ResW = fls_pkg::ResW;
  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // angle_0 .. angle_3, 32 bits each, lowest first
  logic [InW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // sin_0 .. sin_3, then cos_0 .. cos_3, 32 bits each
  logic [OutW-1:0] m_axis_tdata;

  logic [OutW-1:0] trig_queue[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit sender_done = 1'b0;

  four_lane_sine_cosine #(.LANES(NumLanes)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // Round v / 2^s to nearest, halves upwards (arithmetic shift is a floor).
  function automatic logic signed [127:0] rnd_shift(logic signed [127:0] v, int s);
    return (v + (128'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [127:0] q30_mul(logic signed [127:0] a,
                                                  logic signed [127:0] b);
    return rnd_shift(a * b, 30);
  endfunction

  // Expected sine and cosine words of one item.
  function automatic logic [OutW-1:0] predict_sincos(logic [InW-1:0] angles);
    logic [OutW-1:0] res;
    logic signed [127:0] x, n, r, a, z, ts, tc, s, c;
    bit flip;
    res = '0;
    for (int i = 0; i < NumLanes; i++) begin
      x = $signed(angles[i*AngW +: AngW]);
      n = rnd_shift(x * 128'(fls_pkg::Inv2PiQ32), 55);
      r = (x <<< 29) - n * 128'(fls_pkg::TwoPiQ52);
      flip = 1'b0;
      // fold anything past a quarter turn back towards zero
      if ((r < 0 ? -r : r) > 128'(fls_pkg::HalfPiQ52)) begin
        r = (r >= 0 ? 128'(fls_pkg::PiQ52) : -128'(fls_pkg::PiQ52)) - r;
        flip = 1'b1;
      end
      a = rnd_shift(r, 22);
      z = q30_mul(a, a);
      ts = 128'(fls_pkg::SinCoef[0]);
      tc = 128'(fls_pkg::CosCoef[0]);
      for (int k = 1; k < 6; k++) begin
        ts = 128'(fls_pkg::SinCoef[k]) + q30_mul(ts, z);
        tc = 128'(fls_pkg::CosCoef[k]) + q30_mul(tc, z);
      end
      s = q30_mul(ts, a);
      c = flip ? -tc : tc;
      res[i*ResW +: ResW] = s[ResW-1:0];
      res[(NumLanes+i)*ResW +: ResW] = c[ResW-1:0];
    end
    return res;
  endfunction

  // Send one item, holding tvalid until accepted; gaps come from the caller.
  task automatic send_angles(logic [InW-1:0] angles);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= angles;
    do @(posedge clk_i); while (!s_axis_tready);
    trig_queue.push_back(predict_sincos(angles));
  endtask

  task automatic idle_sender(int unsigned n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 26353589)) - 13176795); // within +-pi/2
      2: return 32'($signed($urandom_range(0, 105414357)) - 52707178); // +-2pi
      default: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom())};
    endcase
  endfunction

  // Receiver stall pattern: alternate free runs and random stalls.
  initial begin
    forever begin
      @(posedge clk_i);
      if (cycles < 2000 || (cycles / 500) % 3 == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (trig_queue.size() == 0) begin
        if (mismatches < 10) $display("unexpected result %h", m_axis_tdata);
        mismatches++;
      end else begin
        logic [OutW-1:0] want;
        want = trig_queue.pop_front();
        for (int f = 0; f < 2 * NumLanes; f++) begin
          if (want[f*ResW +: ResW] !== m_axis_tdata[f*ResW +: ResW]) begin
            if (mismatches < 10)
              $display("field %0d: expected %h got %h", f, want[f*ResW +: ResW],
                       m_axis_tdata[f*ResW +: ResW]);
            mismatches++;
          end
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_extremes();
    logic [31:0] edge_vals[14] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
      32'h1, 32'h00c90fdb, 32'hff36f025, 32'h01921fb5, 32'hfe6de04b,
      32'h00c90fda, 32'h00c90fdc, 32'h03243f6a, 32'h55555555, 32'haaaaaaaa};
    for (int i = 0; i < 14; i++)
      send_angles({edge_vals[(i+3)%14], edge_vals[(i+2)%14], edge_vals[(i+1)%14],
                   edge_vals[i]});
    // two lanes near the half turn, where the turn estimate may fall short
    for (int i = 0; i < 6; i++)
      send_angles({32'h0192_1fb5 + i, 32'hfe6d_e04b - i, 32'h004_b65f + i, 32'h04b6_5f1 - i});
    idle_sender(0);
  endtask

  task automatic test_random_bursts();
    for (int n = 0; n < 1430;) begin
      int unsigned burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++, n++)
        send_angles({rand_angle(), rand_angle(), rand_angle(), rand_angle()});
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
      if (n > 700 && n < 741) begin
        // let the pipe drain completely at least once
        idle_sender(0);
        while (trig_queue.size() != 0) @(posedge clk_i);
      end
    end
    idle_sender(0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_random_bursts();
    while (trig_queue.size() != 0) @(posedge clk_i);
    repeat (fls_pkg::PipeDepth + 5) @(posedge clk_i);
    if (mismatches == 0 && trig_queue.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
